/* rtl/actr_pkg.sv */
`default_nettype none
package actr_pkg;

    localparam int KeyWidth  = 64;
    localparam int CfgAddrW  = 1;
    localparam int QueueDepth = 4;

    localparam logic [CfgAddrW-1:0] RegKeyHigh = 1'b0;
    localparam logic [CfgAddrW-1:0] RegKeyLow  = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] pkt_num;
        logic [31:0] src_node;
        logic        first;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out_word;

    // queue entry between front and back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic        new_block;
        logic [3:0]  pos;
        logic [127:0] ctr;
    } t_job;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits in bits [127-8*i -: 8]
    function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // subbytes + shiftrows, optional mixcolumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                t[4*c+k] = sbox(get_b(s, 4*((c+k)%4)+k));
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = t[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] p, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = p[127:96]; w1 = p[95:64]; w2 = p[63:32]; w3 = p[31:0];
        tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

/* rtl/actr_front.sv */
`default_nettype none
module actr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire actr_pkg::t_in_word i_word,
    input  wire logic              i_take,
    output actr_pkg::t_job         o_job
);
    logic [127:0] r_ctr, n_ctr, w_base;
    logic [3:0]   r_pos, w_pos;

    always_comb begin
        w_base = r_ctr;
        w_pos  = r_pos;
        if (i_word.first) begin
            w_base = {i_word.pkt_num[7:0], i_word.pkt_num[15:8],
                      i_word.pkt_num[23:16], i_word.pkt_num[31:24], 32'd0,
                      i_word.src_node[7:0], i_word.src_node[15:8],
                      i_word.src_node[23:16], i_word.src_node[31:24], 32'd0};
            w_pos  = 4'd0;
        end
        n_ctr = (w_pos == 4'd0) ? w_base + 128'd1 : w_base;
        o_job.data_byte = i_word.data_byte;
        o_job.last      = i_word.last;
        o_job.new_block = (w_pos == 4'd0);
        o_job.pos       = w_pos;
        o_job.ctr       = w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_pos <= '0;
        end else if (i_take) begin
            r_ctr <= n_ctr;
            r_pos <= w_pos + 4'd1;
        end
    end
endmodule
`default_nettype wire

/* rtl/actr_queue.sv */
`default_nettype none
module actr_queue #(
    parameter int Depth = actr_pkg::QueueDepth,
    parameter int Width = $bits(actr_pkg::t_job)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [Width-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [Width-1:0]      o_data
);
    localparam int AW = $clog2(Depth);
    logic [Width-1:0] r_mem [Depth];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == AW'(Depth-1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == AW'(Depth-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/actr_back.sv */
`default_nettype none
module actr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [actr_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  wire logic [actr_pkg::KeyWidth-1:0] i_cfg_data,
    input  wire logic               i_q_empty,
    input  wire actr_pkg::t_job     i_job,
    output logic                    o_q_pop,
    output logic                    o_empty,
    output actr_pkg::t_out_word     o_word,
    input  wire logic               i_pop
);
    // round keys are generated on the fly from the key registers each block
    logic [63:0]  r_kh, r_kl;
    logic [127:0] r_st, r_rk, r_ks;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic         r_busy;
    logic         r_ov;
    actr_pkg::t_out_word r_out;
    logic [127:0] w_rk_next, w_rnd_out, w_ks;
    logic         w_slot, w_go, w_start;

    assign w_rk_next = actr_pkg::key_step(r_rk, r_rc);
    assign w_rnd_out = actr_pkg::aes_round(r_st, r_rnd != 4'd10) ^ w_rk_next;
    assign w_slot    = !r_ov || i_pop;
    // head word needs a fresh block: start the round unit, then finish
    assign w_start   = !i_q_empty && i_job.new_block && !r_busy;
    assign w_go      = !i_q_empty && w_slot && (!i_job.new_block ||
                       (r_busy && r_rnd == 4'd10));
    assign w_ks      = (i_job.new_block) ? w_rnd_out : r_ks;
    assign o_q_pop   = w_go;
    assign o_empty   = !r_ov;
    assign o_word    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh <= '0;
            r_kl <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                actr_pkg::RegKeyHigh: r_kh <= i_cfg_data;
                actr_pkg::RegKeyLow:  r_kl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_rnd  <= '0;
            r_ks   <= '0;
        end else begin
            if (w_start) begin
                r_busy <= 1'b1;
                r_rnd  <= 4'd1;
                r_st   <= i_job.ctr ^ {r_kh, r_kl};
                r_rk   <= {r_kh, r_kl};
                r_rc   <= 8'h01;
            end else if (r_busy && r_rnd != 4'd10) begin
                r_rnd <= r_rnd + 4'd1;
                r_st  <= w_rnd_out;
                r_rk  <= w_rk_next;
                r_rc  <= actr_pkg::xtime(r_rc);
            end else if (w_go) begin
                r_busy <= 1'b0;
            end
            if (w_go) begin
                if (i_job.new_block) r_ks <= w_ks;
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out.data_out <= i_job.data_byte ^ w_ks[127 - 8*i_job.pos -: 8];
            r_out.last_out <= i_job.last;
        end
    end
endmodule
`default_nettype wire

/* rtl/aes128_ctr_packet_cipher.sv */
// channel | handshake        | payload
// input   | i_push / o_full  | i_word (t_in_word)
// result  | o_empty / i_pop  | o_word (t_out_word)
// config  | i_cfg_we         | i_cfg_addr, i_cfg_data
// one byte per cycle within a block while words wait and the result is taken; the
// first byte of each 16-byte block holds the queue head while the round unit runs
// (key add, then one aes round per cycle); throughput is limited by the round unit
// reset is synchronous active low and clears counter, position and key registers
// a 4-entry queue between classifier and round unit absorbs stalls on either side
`default_nettype none
module aes128_ctr_packet_cipher #(
    parameter int QDepth = actr_pkg::QueueDepth
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire actr_pkg::t_in_word  i_word,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output actr_pkg::t_out_word      o_word,
    input  wire logic                i_cfg_we,
    input  wire logic [actr_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  wire logic [actr_pkg::KeyWidth-1:0] i_cfg_data
);
    actr_pkg::t_job w_in_job, w_hd_job;
    logic w_q_empty, w_q_pop;

    actr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(i_word),
        .i_take(i_push && !o_full), .o_job(w_in_job)
    );

    actr_queue #(.Depth(QDepth), .Width($bits(actr_pkg::t_job))) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_data(w_in_job),
        .o_full(o_full), .i_pop(w_q_pop), .o_empty(w_q_empty), .o_data(w_hd_job)
    );

    actr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_q_empty(w_q_empty), .i_job(w_hd_job), .o_q_pop(w_q_pop),
        .o_empty(o_empty), .o_word(o_word), .i_pop(i_pop)
    );
endmodule
`default_nettype wire

/* rtl/actr_checker.sv */
`default_nettype none
module actr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_push,
    input wire logic               o_full,
    input wire logic               o_empty,
    input wire logic               i_pop,
    input wire actr_pkg::t_out_word o_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_word))) else $error("result lost");
    a_empty_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty) else $error("result after reset");
    a_full_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_full) else $error("full after reset");
    // the queue can only fill up through an offered word
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_full && !i_push) |=> !o_full)
        else $error("full without a word");
endmodule

bind aes128_ctr_packet_cipher actr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
    .o_empty(o_empty), .i_pop(i_pop), .o_word(o_word)
);
`default_nettype wire

/* tb/aes128_ctr_packet_cipher_tb.sv */
`default_nettype none
module aes128_ctr_packet_cipher_tb;

    localparam int StallLimit = 20000;

    // independent software model of the ctr keystream
    class ctr_keystream_board;
        byte unsigned sb[256];
        byte unsigned rk[11][16];
        byte unsigned ctr[16];
        byte unsigned ks[16];
        int unsigned pos;
        logic [63:0] key_hi, key_lo;
        actr_pkg::t_out_word pending[$];
        int errors;

        function new();
            byte unsigned p, q, x;
            p = 1; q = 1;
            // build the s-box from field inverse and affine map
            sb[0] = 8'h63;
            do begin
                p = p ^ (p << 1) ^ ((p & 8'h80) ? 8'h1b : 8'h00);
                q = q ^ (q << 1);
                q = q ^ (q << 2);
                q = q ^ (q << 4);
                if (q & 8'h80) q = q ^ 8'h09;
                x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                    ^ {q[3:0], q[7:4]};
                sb[p] = x ^ 8'h63;
            end while (p != 1);
            key_hi = '0; key_lo = '0; errors = 0;
            clear_stream();
            expand();
        endfunction

        function void clear_stream();
            foreach (ctr[i]) begin
                ctr[i] = 0; ks[i] = 0;
            end
            pos = 0;
        endfunction

        function byte unsigned dbl(byte unsigned v);
            return (v << 1) ^ ((v & 8'h80) ? 8'h1b : 8'h00);
        endfunction

        function void expand();
            byte unsigned rc;
            rc = 1;
            for (int b = 0; b < 8; b++) begin
                rk[0][b] = key_hi[63-8*b -: 8];
                rk[0][8+b] = key_lo[63-8*b -: 8];
            end
            for (int n = 1; n <= 10; n++) begin
                rk[n][0] = rk[n-1][0] ^ sb[rk[n-1][13]] ^ rc;
                rk[n][1] = rk[n-1][1] ^ sb[rk[n-1][14]];
                rk[n][2] = rk[n-1][2] ^ sb[rk[n-1][15]];
                rk[n][3] = rk[n-1][3] ^ sb[rk[n-1][12]];
                for (int b = 4; b < 16; b++) rk[n][b] = rk[n-1][b] ^ rk[n][b-4];
                rc = dbl(rc);
            end
        endfunction

        function void set_key(bit idx, logic [63:0] v);
            if (idx == actr_pkg::RegKeyHigh) key_hi = v; else key_lo = v;
            expand();
        endfunction

        function void encrypt();
            byte unsigned st[16], t[16], a0, a1, a2, a3, al;
            foreach (st[i]) st[i] = ctr[i] ^ rk[0][i];
            for (int r = 1; r <= 10; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int k = 0; k < 4; k++) t[4*c+k] = sb[st[4*((c+k)%4)+k]];
                if (r < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        t[4*c] = a0 ^ al ^ dbl(a0 ^ a1);
                        t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                        t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                        t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                    end
                end
                foreach (st[i]) st[i] = t[i] ^ rk[r][i];
            end
            ks = st;
        endfunction

        function void note_byte(actr_pkg::t_in_word w);
            actr_pkg::t_out_word o;
            if (w.first) begin
                foreach (ctr[i]) ctr[i] = 0;
                for (int i = 0; i < 4; i++) begin
                    ctr[i] = w.pkt_num[8*i +: 8];
                    ctr[8+i] = w.src_node[8*i +: 8];
                end
                pos = 0;
            end
            if (pos == 0) begin
                encrypt();
                for (int i = 15; i >= 0; i--) begin
                    ctr[i]++;
                    if (ctr[i] != 0) break;
                end
            end
            o.data_out = w.data_byte ^ ks[pos];
            o.last_out = w.last;
            pending.push_back(o);
            pos = (pos + 1) % 16;
        endfunction

        task report_mismatch(string what, int exp_v, int got_v);
            $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
            errors++;
        endtask

        task check_word(actr_pkg::t_out_word got);
            actr_pkg::t_out_word exp_w;
            if (pending.size() == 0) begin
                report_mismatch("word with nothing expected", 0, int'(got.data_out));
                return;
            end
            exp_w = pending.pop_front();
            if (got.data_out !== exp_w.data_out)
                report_mismatch("data_out", int'(exp_w.data_out), int'(got.data_out));
            if (got.last_out !== exp_w.last_out)
                report_mismatch("last_out", int'(exp_w.last_out), int'(got.last_out));
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_push = 0, i_pop = 0, i_cfg_we = 0;
    logic o_full, o_empty;
    actr_pkg::t_in_word i_word = '0;
    actr_pkg::t_out_word o_word;
    logic [actr_pkg::CfgAddrW-1:0] i_cfg_addr = '0;
    logic [actr_pkg::KeyWidth-1:0] i_cfg_data = '0;

    ctr_keystream_board board;
    int send_idle = 0, recv_idle = 0, hold_cycles = 0, quiet = 0;

    aes128_ctr_packet_cipher dut (.*);

    always #5 i_clk = ~i_clk;

    // receiver: random pop, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_pop <= 0;
        end else begin
            i_pop <= i_rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) board.check_word(o_word);
            if ((i_pop && !o_empty) || (i_push && !o_full) || i_cfg_we) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= StallLimit) begin
                $display("aes128_ctr_packet_cipher regression: fail");
                $finish;
            end
        end
    end

    // push stays high between back-to-back words; idle gaps and drain drop it
    task automatic send_byte(actr_pkg::t_in_word w);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_push <= 0;
            @(negedge i_clk);
        end
        i_word <= w;
        i_push <= 1;
        do @(posedge i_clk); while (o_full);
        board.note_byte(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_push <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_key(bit idx, logic [63:0] v);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_key(idx, v);
        @(negedge i_clk);
    endtask

    function automatic actr_pkg::t_in_word rand_word(bit first, bit last);
        actr_pkg::t_in_word w;
        w.data_byte = 8'($urandom);
        w.pkt_num = $urandom;
        w.src_node = $urandom;
        w.first = first;
        w.last = last;
        return w;
    endfunction

    task automatic send_packet(int len);
        for (int i = 0; i < len; i++) send_byte(rand_word(i == 0, i == len - 1));
    endtask

    task automatic random_mix(int n);
        int left;
        left = n;
        while (left > 0) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 40) : $urandom_range(33, 1);
            if (len > left) len = left;
            if ($urandom_range(7) == 0) begin
                // noise: bytes with random flags
                for (int i = 0; i < len; i++)
                    send_byte(rand_word(1'($urandom), 1'($urandom)));
            end else begin
                send_packet(len);
            end
            left -= len;
        end
    endtask

    initial begin
        actr_pkg::t_in_word w;
        board = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // stream with no packet start runs from the zero counter and zero key
        for (int i = 0; i < 18; i++) send_byte(rand_word(0, i == 17));
        drain();

        write_key(actr_pkg::RegKeyHigh, 64'h2b7e151628aed2a6);
        write_key(actr_pkg::RegKeyLow, 64'habf7158809cf4f3c);
        // nonce extremes, data extremes
        w = '{data_byte: 8'h00, pkt_num: 32'h0, src_node: 32'h0, first: 1, last: 0};
        send_byte(w);
        w = '{data_byte: 8'hff, pkt_num: 32'hffffffff, src_node: 32'hffffffff,
              first: 1, last: 0};
        send_byte(w);
        for (int i = 0; i < 17; i++) send_byte(rand_word(0, i == 16));
        // bytes after last continue the stream, then a short packet
        send_byte(rand_word(0, 0));
        send_byte(rand_word(1, 1));
        drain();

        // key change mid-stream: current block is kept, new keys from next one
        send_byte(rand_word(1, 0));
        drain();
        write_key(actr_pkg::RegKeyLow, 64'hffffffffffffffff);
        for (int i = 0; i < 18; i++) send_byte(rand_word(0, i == 17));
        drain();

        send_idle = 32; recv_idle = 63;
        write_key(actr_pkg::RegKeyHigh, 64'hffffffffffffffff);
        random_mix(270);
        drain();

        send_idle = 63; recv_idle = 32;
        write_key(actr_pkg::RegKeyHigh, {$urandom, $urandom});
        write_key(actr_pkg::RegKeyLow, {$urandom, $urandom});
        random_mix(270);
        drain();

        send_idle = 0; recv_idle = 0;
        write_key(actr_pkg::RegKeyHigh, 64'h0);
        write_key(actr_pkg::RegKeyLow, {$urandom, $urandom});
        // receiver holds off so the queue fills and full rises
        hold_cycles = 300;
        random_mix(260);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("aes128_ctr_packet_cipher regression: pass");
        else
            $display("aes128_ctr_packet_cipher regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
